// ===== design/vmo_pkg.sv =====
// ============================================================================
// vmo_pkg: shared constants for the vector magnitude block
// Sample width default, result width, the fixed one-half offset and the saturation limit.
// ============================================================================
`default_nettype none

package vmo_pkg;

    // Default width of one signed Q8.8 component.
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Width of the unsigned Q8.8 magnitude.
    localparam int MAG_WIDTH = 16;

    // One half in Q8.8.
    localparam logic [MAG_WIDTH-1:0] HALF_Q8 = 16'd128;

    // Largest magnitude that the result field can carry.
    localparam logic [MAG_WIDTH-1:0] MAG_MAX = 16'hFFFF;

endpackage : vmo_pkg

`default_nettype wire

// ===== design/vmo_if.sv =====
// ============================================================================
// vmo_in_if / vmo_out_if: item channels of the vector magnitude block
// Valid/ready channels carrying one element pair in and one magnitude out.
// ============================================================================
`default_nettype none

interface vmo_in_if #(
    parameter int SAMPLE_WIDTH = vmo_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic                           last_in;

    modport source (output valid, output x_value, output y_value, output last_in,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input last_in,
                    output ready);
endinterface : vmo_in_if

interface vmo_out_if;
    logic                           valid;
    logic                           ready;
    logic [vmo_pkg::MAG_WIDTH-1:0]  magnitude;
    logic                           last_out;

    modport source (output valid, output magnitude, output last_out, input ready);
    modport sink   (input valid, input magnitude, input last_out, output ready);
endinterface : vmo_out_if

`default_nettype wire

// ===== design/vector_magnitude_offset.sv =====
// ============================================================================
// vector_magnitude_offset: per-element magnitude plus one half
// Streams (x, y) pairs in Q8.8 and returns floor(sqrt(x*x + y*y)) + 0.5.
// ============================================================================
// Usage
//   Items arrive on the pair channel: x_value and y_value are signed Q8.8
//   samples of SAMPLE_WIDTH bits, last_in marks the final element of a
//   vector. Each item yields exactly one result item on the result channel,
//   with magnitude in unsigned Q8.8 and last_out copied from last_in.
//   Both channels move an item at a clock edge where valid and ready are high.
//
//   From acceptance to result valid, three front stages form the square sum,
//   one root cell per root bit settles the square root, and an output
//   register adds one half. Throughput is one item per cycle while the
//   receiver does not stall the result channel.
//
//   Every stage has its own valid bit and takes a new item when it is empty
//   or its item moves on, so a stalled receiver holds the result register
//   while earlier stages keep filling their free slots; pair.ready falls only
//   when the whole chain is full. The block holds no state beyond items in
//   flight. An asynchronous reset empties the pipeline at once.
// ============================================================================
`default_nettype none

module vector_magnitude_offset #(
    parameter int SAMPLE_WIDTH = vmo_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vmo_in_if.sink    pair,
    vmo_out_if.source result
);
    import vmo_pkg::*;

    localparam int ROOT_W = SAMPLE_WIDTH;
    localparam int SUM_W  = 2 * SAMPLE_WIDTH;

    // Links between neighbors in the chain; index k feeds root cell k.
    logic              link_valid [0:ROOT_W];
    logic              link_ready [0:ROOT_W];
    logic [ROOT_W+1:0] link_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] link_root  [0:ROOT_W];
    logic [SUM_W-1:0]  link_rad   [0:ROOT_W];
    logic              link_last  [0:ROOT_W];

    // Square sum of the magnitudes, exact in twice the sample width.
    vmo_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .down_valid (link_valid[0]),
        .down_ready (link_ready[0]),
        .sum        (link_rad[0]),
        .last       (link_last[0])
    );

    // The first cell starts with an empty remainder and root.
    assign link_rem[0]  = '0;
    assign link_root[0] = '0;

    // One cell for each root bit, most significant first.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_cell
        vmo_root_cell #(
            .ROOT_W (ROOT_W),
            .SUM_W  (SUM_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[k]),
            .up_ready   (link_ready[k]),
            .rem_in     (link_rem[k]),
            .root_in    (link_root[k]),
            .rad_in     (link_rad[k]),
            .last_in    (link_last[k]),
            .down_valid (link_valid[k+1]),
            .down_ready (link_ready[k+1]),
            .rem_out    (link_rem[k+1]),
            .root_out   (link_root[k+1]),
            .rad_out    (link_rad[k+1]),
            .last_out   (link_last[k+1])
        );
    end

    // Add one half, saturate to the result width and hold for the receiver.
    vmo_back #(
        .ROOT_W (ROOT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[ROOT_W]),
        .up_ready (link_ready[ROOT_W]),
        .root     (link_root[ROOT_W]),
        .last     (link_last[ROOT_W]),
        .result   (result)
    );

endmodule : vector_magnitude_offset

`default_nettype wire

// ===== design/vmo_front.sv =====
// ============================================================================
// vmo_front: absolute value, squaring and square sum
// Three registered stages that turn an element pair into its exact square sum.
// ============================================================================
`default_nettype none

module vmo_front #(
    parameter int SAMPLE_WIDTH = vmo_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    vmo_in_if.sink                         pair,
    output logic                           down_valid,
    input  wire logic                      down_ready,
    output logic [2*SAMPLE_WIDTH-1:0]      sum,
    output logic                           last
);
    localparam int W = SAMPLE_WIDTH;

    // Stage 1: magnitudes of both components.
    logic           abs_valid_reg;
    logic [W-1:0]   abs_x_reg, abs_y_reg, abs_x_next, abs_y_next;
    logic           abs_last_reg;
    logic           abs_ready;

    // Stage 2: squares.
    logic           sq_valid_reg;
    logic [2*W-1:0] sq_x_reg, sq_y_reg;
    logic           sq_last_reg;
    logic           sq_ready;

    // Stage 3: square sum.
    logic           sum_valid_reg;
    logic [2*W-1:0] sum_reg;
    logic           sum_last_reg;

    // A stage takes a new item when it is empty or its item moves on.
    assign abs_ready  = !sq_valid_reg || sq_ready;
    assign sq_ready   = !sum_valid_reg || down_ready;
    assign pair.ready = !abs_valid_reg || abs_ready;

    // The most negative value negates to itself, which as unsigned is its magnitude.
    always_comb
    begin
        abs_x_next = pair.x_value[W-1] ? (~pair.x_value + 1'b1) : pair.x_value;
        abs_y_next = pair.y_value[W-1] ? (~pair.y_value + 1'b1) : pair.y_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (pair.ready)
                abs_valid_reg <= pair.valid;
            if (abs_ready)
                sq_valid_reg <= abs_valid_reg;
            if (sq_ready)
                sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.ready && pair.valid)
        begin
            abs_x_reg    <= abs_x_next;
            abs_y_reg    <= abs_y_next;
            abs_last_reg <= pair.last_in;
        end
        if (abs_ready && abs_valid_reg)
        begin
            sq_x_reg    <= abs_x_reg * abs_x_reg;
            sq_y_reg    <= abs_y_reg * abs_y_reg;
            sq_last_reg <= abs_last_reg;
        end
        if (sq_ready && sq_valid_reg)
        begin
            sum_reg      <= sq_x_reg + sq_y_reg;
            sum_last_reg <= sq_last_reg;
        end
    end

    assign down_valid = sum_valid_reg;
    assign sum        = sum_reg;
    assign last       = sum_last_reg;

endmodule : vmo_front

`default_nettype wire

// ===== design/vmo_root_cell.sv =====
// ============================================================================
// vmo_root_cell: one digit of the integer square root
// Takes the next two radicand bits and settles one root bit per item.
// ============================================================================
`default_nettype none

module vmo_root_cell #(
    parameter int ROOT_W = vmo_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_W  = 2 * vmo_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire logic [ROOT_W+1:0]   rem_in,
    input  wire logic [ROOT_W-1:0]   root_in,
    input  wire logic [SUM_W-1:0]    rad_in,
    input  wire logic                last_in,
    output logic                     down_valid,
    input  wire logic                down_ready,
    output logic [ROOT_W+1:0]        rem_out,
    output logic [ROOT_W-1:0]        root_out,
    output logic [SUM_W-1:0]         rad_out,
    output logic                     last_out
);
    logic                valid_reg;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [SUM_W-1:0]    rad_reg;
    logic                last_reg;
    logic [ROOT_W+3:0]   shifted;
    logic [ROOT_W+3:0]   trial;
    logic [ROOT_W+3:0]   diff;

    assign up_ready = !valid_reg || down_ready;

    // Bring down two radicand bits and try the root with a one appended.
    always_comb
    begin
        shifted = {rem_in, rad_in[SUM_W-1 -: 2]};
        trial   = {2'b00, root_in, 2'b01};
        diff    = shifted - trial;
        if (shifted >= trial)
        begin
            rem_next  = diff[ROOT_W+1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted[ROOT_W+1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[SUM_W-3:0], 2'b00};
            last_reg <= last_in;
        end
    end

    assign down_valid = valid_reg;
    assign rem_out    = rem_reg;
    assign root_out   = root_reg;
    assign rad_out    = rad_reg;
    assign last_out   = last_reg;

endmodule : vmo_root_cell

`default_nettype wire

// ===== design/vmo_back.sv =====
// ============================================================================
// vmo_back: offset, saturation and output register
// Adds one half to the root and holds the result item for the receiver.
// ============================================================================
`default_nettype none

module vmo_back #(
    parameter int ROOT_W = vmo_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire logic [ROOT_W-1:0]  root,
    input  wire logic               last,
    vmo_out_if.source               result
);
    import vmo_pkg::*;

    localparam int MW = ((ROOT_W > MAG_WIDTH) ? ROOT_W : MAG_WIDTH) + 1;

    logic                 valid_reg;
    logic [MAG_WIDTH-1:0] mag_reg, mag_next;
    logic                 last_reg;
    logic [MW-1:0]        total;

    assign up_ready = !valid_reg || result.ready;

    always_comb
    begin
        total = MW'(root) + MW'(HALF_Q8);
        if (total[MW-1:MAG_WIDTH] != '0)
            mag_next = MAG_MAX;
        else
            mag_next = total[MAG_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            mag_reg  <= mag_next;
            last_reg <= last;
        end
    end

    assign result.valid     = valid_reg;
    assign result.magnitude = mag_reg;
    assign result.last_out  = last_reg;

endmodule : vmo_back

`default_nettype wire

// ===== design/vmo_checker.sv =====
// ============================================================================
// vmo_checker: port-level checks for the vector magnitude block
// Watches the two channels and the reset of the top level.
// ============================================================================
`default_nettype none

module vmo_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pair_valid,
    input wire logic                          pair_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [vmo_pkg::MAG_WIDTH-1:0] magnitude,
    input wire logic                          last_out
);
    import vmo_pkg::*;

    // A held result keeps its payload until the receiver takes it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(magnitude)
                                          && $stable(last_out))
        else $error("result item changed while stalled");

    // The half offset means every magnitude is at least one half.
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> magnitude >= HALF_Q8)
        else $error("magnitude below one half");

    // When the output register is free, the whole chain can take an item.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ready || !result_valid) |-> pair_ready)
        else $error("input stalled while output side is free");

    // Reset leaves the pipeline empty.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule : vmo_checker

bind vector_magnitude_offset vmo_checker u_vmo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_valid   (pair.valid),
    .pair_ready   (pair.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .magnitude    (result.magnitude),
    .last_out     (result.last_out)
);

`default_nettype wire

// ===== test/tb_vector_magnitude_offset.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_vector_magnitude_offset: self-checking bench for the magnitude pipeline
// Streams (x, y) element pairs through the block and checks every result
// against an independent fixed-point prediction of isqrt(x*x + y*y) + 0.5,
// while both channels idle in random bursts and the sender drains the
// pipeline at least once.
// ============================================================================

module tb_vector_magnitude_offset;

    import vmo_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    // Cycle limit for the run, with a wide margin over a correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1500;
    // Bursts of idling stop once this few items are left to send.
    localparam int QUIET_TAIL  = 150;

    // One pending element pair. drain_first holds the sender back until
    // every result already expected has come out of the block.
    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic                 last;
        bit                   drain_first;
    } pair_item_t;

    // One expected result item.
    typedef struct {
        logic [MAG_WIDTH-1:0] magnitude;
        logic                 last;
    } mag_item_t;

    logic clk = 1'b0;
    logic rst_n;

    vmo_in_if #(.SAMPLE_WIDTH(SW)) pair_if ();
    vmo_out_if                     result_if ();

    vector_magnitude_offset #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_if),
        .result (result_if)
    );

    // Items waiting to be sent, and results waiting to be seen, oldest first.
    pair_item_t pair_queue[$];
    mag_item_t  magnitude_queue[$];

    int error_count    = 0;
    int sent_count     = 0;
    int received_count = 0;
    int cycle_count    = 0;
    int send_gap       = 0;
    int stall_left     = 0;

    pair_item_t next_pair;
    mag_item_t  want;
    mag_item_t  oldest;

    // Component values at the ends of the signed range and around zero.
    logic signed [SW-1:0] corner_values [6] = '{
        16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The block rounds nothing: the root is the exact floor square root of
    // the Q16.16 square sum, so the prediction searches the root bit by bit
    // from the top, keeping a bit whenever its square still fits.
    function automatic logic [MAG_WIDTH-1:0] predict_magnitude(
        input logic signed [SW-1:0] x,
        input logic signed [SW-1:0] y
    );
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned square_sum;
        longint unsigned root;
        longint unsigned trial;
        // The sign extension in the cast makes -32768 come out as +32768.
        ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
        ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
        square_sum = ax * ax + ay * ay;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= square_sum)
                root = trial;
        end
        root = root + HALF_Q8;
        // Only reachable with wider samples, but the result field saturates.
        if (root > MAG_MAX)
            root = MAG_MAX;
        return root[MAG_WIDTH-1:0];
    endfunction

    task automatic add_pair(
        input logic signed [SW-1:0] x,
        input logic signed [SW-1:0] y,
        input logic                 last,
        input bit                   drain_first
    );
        pair_item_t item;
        item.x           = x;
        item.y           = y;
        item.last        = last;
        item.drain_first = drain_first;
        pair_queue.push_back(item);
    endtask

    // Sender. Every accepted item is turned into an expectation at the same
    // edge. When the slot is free, the sender either idles for the rest of a
    // burst, waits for the pipeline to drain, or puts up the next item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_if.valid   <= 1'b0;
            pair_if.x_value <= '0;
            pair_if.y_value <= '0;
            pair_if.last_in <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (pair_if.valid && pair_if.ready)
            begin
                want.magnitude = predict_magnitude(pair_if.x_value, pair_if.y_value);
                want.last      = pair_if.last_in;
                magnitude_queue.push_back(want);
                sent_count++;
            end
            if (!pair_if.valid || pair_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pair_if.valid <= 1'b0;
                end
                else if (pair_queue.size() == 0)
                    pair_if.valid <= 1'b0;
                else if (pair_queue[0].drain_first && magnitude_queue.size() != 0)
                    pair_if.valid <= 1'b0;
                else
                begin
                    next_pair = pair_queue.pop_front();
                    pair_if.valid   <= 1'b1;
                    pair_if.x_value <= next_pair.x;
                    pair_if.y_value <= next_pair.y;
                    pair_if.last_in <= next_pair.last;
                    // Idling density changes every 128 items: none, light, heavy.
                    if (pair_queue.size() >= QUIET_TAIL)
                    begin
                        case ((sent_count / 128) % 3)
                            1: if ($urandom_range(0, 15) == 0)
                                   send_gap = $urandom_range(1, 18);
                            2: if ($urandom_range(0, 2) == 0)
                                   send_gap = $urandom_range(1, 18);
                            default: send_gap = 0;
                        endcase
                    end
                end
            end
        end
    end

    // Receiver. Each accepted result is checked against the oldest
    // expectation; ready then follows its own burst pattern, with a period
    // different from the sender's so that stalls land on every phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                received_count++;
                if (magnitude_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: magnitude=%0d last_out=%0b",
                                 result_if.magnitude, result_if.last_out);
                end
                else
                begin
                    oldest = magnitude_queue.pop_front();
                    if (result_if.magnitude !== oldest.magnitude ||
                        result_if.last_out !== oldest.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch at result %0d: magnitude %0d/%0d last_out %0b/%0b",
                                     received_count, oldest.magnitude, result_if.magnitude,
                                     oldest.last, result_if.last_out);
                    end
                end
            end
            if (pair_queue.size() < QUIET_TAIL)
                result_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (((received_count / 96) % 3 == 1 && $urandom_range(0, 11) == 0) ||
                     ((received_count / 96) % 3 == 2 && $urandom_range(0, 3) == 0))
            begin
                stall_left = $urandom_range(1, 18) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // A hung pipeline ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_vector_magnitude_offset: errors");
            $finish;
        end
    end

    initial
    begin
        int vec_len;
        int style;
        int made;
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic last;

        rst_n = 1'b0;

        // Directed part: zero, the range ends, the most negative value on
        // both components (square sum of 2^31), exact and truncated roots.
        add_pair(16'sh0000, 16'sh0000, 1'b0, 1'b0);
        add_pair(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        add_pair(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        add_pair(16'sh8000, 16'sh0000, 1'b1, 1'b0);
        add_pair(16'sh0000, 16'sh8000, 1'b0, 1'b0);
        add_pair(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
        add_pair(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        add_pair(16'shFFFF, 16'shFFFF, 1'b0, 1'b0);
        add_pair(16'sh0001, 16'sh0000, 1'b1, 1'b0);
        add_pair(16'sh0000, 16'sh0001, 1'b1, 1'b0);
        add_pair(16'sh0001, 16'sh0001, 1'b0, 1'b0);
        // 3-4-5 gives an exact root; 3-5 must truncate sqrt(34) down to 5.
        add_pair(16'sh0003, 16'sh0004, 1'b0, 1'b0);
        add_pair(16'sh0003, 16'sh0005, 1'b1, 1'b0);
        add_pair(16'shFFFD, 16'shFFFB, 1'b0, 1'b0);
        add_pair(16'sh0100, 16'sh0100, 1'b1, 1'b0);
        add_pair(16'sh00FF, 16'shFF01, 1'b0, 1'b0);
        add_pair(16'sh5555, 16'shAAAA, 1'b1, 1'b0);
        add_pair(16'shAAAA, 16'sh5555, 1'b0, 1'b0);
        add_pair(16'sh8001, 16'sh8001, 1'b1, 1'b0);

        // Random part: mostly whole vectors with last on the final element,
        // with random content drawn from the full range, small values or
        // corners, plus some vectors with a scrambled last flag. The sender
        // drains the pipeline before the first random item and midway.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            vec_len = $urandom_range(1, 16);
            style   = $urandom_range(0, 9);
            for (int i = 0; i < vec_len; i++)
            begin
                case (style)
                    6, 7:
                    begin
                        x = SW'(int'($urandom_range(0, 1023)) - 512);
                        y = SW'(int'($urandom_range(0, 1023)) - 512);
                    end
                    8:
                    begin
                        x = corner_values[$urandom_range(0, 5)];
                        y = corner_values[$urandom_range(0, 5)];
                    end
                    default:
                    begin
                        x = SW'($urandom());
                        y = SW'($urandom());
                    end
                endcase
                if (style == 9)
                    last = 1'($urandom_range(0, 1));
                else
                    last = (i == vec_len - 1);
                add_pair(x, y, last, made == 0 || made == RANDOM_ITEMS / 2);
                made++;
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be sent, then for every result to come out,
        // then a little past the pipeline depth to catch stray results.
        do
            @(posedge clk);
        while (pair_queue.size() != 0 || pair_if.valid);
        while (magnitude_queue.size() != 0)
            @(posedge clk);
        repeat (SW + 12) @(posedge clk);

        if (error_count == 0 && magnitude_queue.size() == 0)
            $display("tb_vector_magnitude_offset: clean");
        else
            $display("tb_vector_magnitude_offset: errors");
        $finish;
    end

endmodule : tb_vector_magnitude_offset

// ===== vector_magnitude_offset.f =====
design/vmo_pkg.sv
design/vmo_if.sv
design/vmo_front.sv
design/vmo_root_cell.sv
design/vmo_back.sv
design/vector_magnitude_offset.sv
design/vmo_checker.sv
test/tb_vector_magnitude_offset.sv
